[hw/rtl/recent_packet_duplicate_filter_unit_defines.svh]
// assertion macros for the recent packet duplicate filter
// used by recent_packet_duplicate_filter_unit; no other dependencies
`ifndef RECENT_PACKET_DUPLICATE_FILTER_UNIT_DEFINES_SVH
`define RECENT_PACKET_DUPLICATE_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define RPDF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RPDF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/rpdf_pkg.sv]
// shared types and constants of the recent packet duplicate filter
// no dependencies
`timescale 1ns / 1ps

package rpdf_pkg;

   localparam logic [31:0] DUP_WINDOW_RESET = 32'd10000;

   // register index taken from the word address
   localparam logic CSR_DUP_WINDOW = 1'b0;

   localparam int CSR_ADDR_W = 3;

   typedef struct packed {
      logic [31:0] frame_id;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        is_duplicate;
      logic [3:0]  slot_written;
   } rsp_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] stamp;
   } entry_type;

endpackage

[hw/rtl/rpdf_table.sv]
// id/time table: one synchronous memory, registered read, per-entry valid bits
// depends on rpdf_pkg
`timescale 1ns / 1ps

module rpdf_table #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output rpdf_pkg::entry_type               rd_entry,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  rpdf_pkg::entry_type               wr_entry
);

   rpdf_pkg::entry_type mem [DEPTH];
   logic [DEPTH-1:0]    vld_ff;
   rpdf_pkg::entry_type rd_data_ff;
   logic                rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // never-written entries read as free with time zero
   assign rd_entry = rd_vld_ff ? rd_data_ff : '0;

endmodule

[hw/rtl/recent_packet_duplicate_filter_unit.sv]
// top level of the recent packet duplicate filter: scan sequencer, csr, result beat
// depends on rpdf_pkg, rpdf_table and recent_packet_duplicate_filter_unit_defines.svh
`timescale 1ns / 1ps

// One packet at a time: a beat is taken when start is high and busy low, and its
// result is shown on rsp_valid for one cycle, registered from the commit state after
// the scan and drain states have run; the receiver cannot stall it. busy stays high
// through the scan, drain and commit states, so a new packet may be started in the
// cycle the previous result is shown. The pace is set by one pass over the table
// through its single read port, one entry per cycle, plus a drain state for the last
// read to land and a commit state to write back. The table is empty right after
// reset; no clearing pass is needed. dup_window_ms sits at byte address 0.

`include "recent_packet_duplicate_filter_unit_defines.svh"

module recent_packet_duplicate_filter_unit #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  rpdf_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output rpdf_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rpdf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   rpdf_pkg::req_type   req_ff;
   logic [31:0]         window_ff;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                eval_vld_ff;
   logic [IDX_W-1:0]    eval_idx_ff;
   logic                dup_ff, dup_in;
   logic                free_found_ff, free_found_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [31:0]         min_time_ff, min_time_in;
   logic [IDX_W-1:0]    min_idx_ff, min_idx_in;
   logic                rsp_valid_ff;
   rpdf_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   rpdf_pkg::entry_type rd_entry;
   rpdf_pkg::entry_type wr_entry;
   logic                wr_en;
   logic [IDX_W-1:0]    victim;
   logic [IDX_W+3:0]    victim_ext;
   logic [31:0]         age;
   logic                in_window;
   logic                accept;
   logic                csr_wr;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // csr
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == rpdf_pkg::CSR_DUP_WINDOW) ? window_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= rpdf_pkg::DUP_WINDOW_RESET;
      end else if (csr_wr && paddr[2] == rpdf_pkg::CSR_DUP_WINDOW) begin
         window_ff <= pwdata;
      end
   end

   rpdf_table #(
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_idx_ff),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (victim),
      .wr_entry (wr_entry)
   );

   // per-entry evaluation
   assign age       = req_ff.now_ms - rd_entry.stamp;
   assign in_window = (age <= window_ff);

   assign victim     = free_found_ff ? free_idx_ff : min_idx_ff;
   assign victim_ext = (IDX_W + 4)'(victim);
   assign wr_en      = (state_ff == ST_COMMIT) && !dup_ff;
   assign wr_entry   = '{id: req_ff.frame_id, stamp: req_ff.now_ms};

   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      dup_in        = dup_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      min_time_in   = min_time_ff;
      min_idx_in    = min_idx_ff;
      rsp_data_in   = rsp_data_ff;

      if (eval_vld_ff) begin
         if (rd_entry.id == req_ff.frame_id && in_window) begin
            dup_in = 1'b1;
         end
         if (!free_found_ff && (rd_entry.id == 32'd0 || !in_window)) begin
            free_found_in = 1'b1;
            free_idx_in   = eval_idx_ff;
         end
         if (eval_idx_ff == '0 || rd_entry.stamp < min_time_ff) begin
            min_time_in = rd_entry.stamp;
            min_idx_in  = eval_idx_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in      = ST_SCAN;
               rd_idx_in     = '0;
               dup_in        = 1'b0;
               free_found_in = 1'b0;
            end
         end
         ST_SCAN: begin
            rd_idx_in = rd_idx_ff + 1'b1;
            if (rd_idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in                 = ST_IDLE;
            rsp_data_in.is_duplicate = dup_ff;
            rsp_data_in.slot_written = dup_ff ? 4'd0 : victim_ext[3:0];
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_idx_ff     <= '0;
         eval_vld_ff   <= 1'b0;
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         eval_vld_ff   <= (state_ff == ST_SCAN);
         dup_ff        <= dup_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= (state_ff == ST_COMMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      eval_idx_ff <= rd_idx_ff;
      free_idx_ff <= free_idx_in;
      min_time_ff <= min_time_in;
      min_idx_ff  <= min_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RPDF_ASSERT_NEXT(a_accept_starts_scan, clock, reset, accept, state_ff == ST_SCAN && rd_idx_ff == '0, "accepted beat did not start a scan")
   `RPDF_ASSERT_NOW(a_rsp_after_commit, clock, reset, rsp_valid, $past(state_ff) == ST_COMMIT, "result beat without commit")
   `RPDF_ASSERT_NEXT(a_single_rsp, clock, reset, rsp_valid, !rsp_valid, "more than one result beat per packet")
   `RPDF_ASSERT_NOW(a_no_write_on_dup, clock, reset, wr_en, !dup_ff && state_ff == ST_COMMIT, "table written on a duplicate")
   `RPDF_ASSERT_NOW(a_eval_during_scan, clock, reset, eval_vld_ff, state_ff == ST_SCAN || state_ff == ST_DRAIN, "entry evaluated outside the scan")

endmodule
